[hdl/shuffled_lehmer_uniform_generator_macros.svh]
// Assertion macros for the shuffled Lehmer uniform generator checker.
// No dependencies; include by bare file name.
`ifndef SHUFFLED_LEHMER_UNIFORM_GENERATOR_MACROS_SVH
`define SHUFFLED_LEHMER_UNIFORM_GENERATOR_MACROS_SVH

// Antecedent in this cycle implies consequent in the next, outside reset.
`define SLUG_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after a reset cycle.
`define SLUG_ASSERT_RESET(label, cons, msg) \
   label: assert property (@(posedge clock) reset |=> (cons)) else $error(msg);

`endif

[hdl/slug_pkg.sv]
// Shared constants, codes and controller/datapath interface types for the
// shuffled Lehmer uniform generator. No dependencies.
`timescale 1ns / 1ps

package slug_pkg;

   // Core generator: x <- 16807 * x mod (2^31 - 1)
   localparam logic [14:0] LEHMER_MUL      = 15'd16807;
   localparam logic [30:0] LEHMER_MOD      = 31'h7FFF_FFFF;
   localparam int          DEF_TABLE_WORDS = 32;
   localparam int          WARM_EXTRA      = 7;

   // Input item function codes
   localparam logic FUNC_DRAW = 1'b0;
   localparam logic FUNC_LOAD = 1'b1;

   // Commands from controller to datapath
   typedef struct packed {
      logic load_seed;   // write seed register from the input beat
      logic start_init;  // form start value, arm the warm-up counter
      logic init_step;   // one warm-up step, fill table when in range
      logic draw_step;   // advance core, read shuffle entry
      logic finish;      // swap entry, update last output and result
   } slug_cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic need_init;   // seed non-positive or last output zero
      logic cnt_zero;    // warm-up counter at its final step
   } slug_sts_type;

endpackage

[hdl/slug_ctrl.sv]
// Sequencer for the shuffled Lehmer uniform generator: handshakes and
// step ordering. Depends on slug_pkg.
`timescale 1ns / 1ps

module slug_ctrl import slug_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  logic         req_func,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output slug_cmd_type cmd,
   input  slug_sts_type sts
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_RWAIT = 3'd1;
   localparam logic [2:0] ST_RFOLD = 3'd2;
   localparam logic [2:0] ST_DWAIT = 3'd3;
   localparam logic [2:0] ST_DFOLD = 3'd4;
   localparam logic [2:0] ST_DONE  = 3'd5;

   logic [2:0] state_ff, state_in;
   logic       valid_ff, valid_in;
   logic       accept;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = valid_ff;
   assign accept    = req_valid && req_ready;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_func == FUNC_LOAD) begin
                  cmd.load_seed = 1'b1;
               end else if (sts.need_init) begin
                  cmd.start_init = 1'b1;
                  state_in       = ST_RWAIT;
               end else begin
                  state_in = ST_DFOLD;
               end
            end
         end
         ST_RWAIT: state_in = ST_RFOLD;
         ST_RFOLD: begin
            cmd.init_step = 1'b1;
            state_in      = sts.cnt_zero ? ST_DWAIT : ST_RWAIT;
         end
         ST_DWAIT: state_in = ST_DFOLD;
         ST_DFOLD: begin
            cmd.draw_step = 1'b1;
            state_in      = ST_DONE;
         end
         ST_DONE: begin
            // hold until the result register is free
            if (!valid_ff || rsp_ready) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      valid_in = valid_ff;
      if (cmd.finish) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

endmodule

[hdl/slug_dp.sv]
// Datapath for the shuffled Lehmer uniform generator: core register,
// multiply/fold step, warm-up counter, shuffle memory. Depends on slug_pkg.
`timescale 1ns / 1ps

module slug_dp import slug_pkg::*; #(
   parameter int TABLE_WORDS = DEF_TABLE_WORDS
) (
   input  logic               clock,
   input  logic               reset,
   input  slug_cmd_type       cmd,
   output slug_sts_type       sts,
   input  logic signed [31:0] req_seed_value,
   output logic        [30:0] rsp_uniform_value
);

   localparam int IDX_W = (TABLE_WORDS > 1) ? $clog2(TABLE_WORDS) : 1;
   localparam int CNT_W = $clog2(TABLE_WORDS + WARM_EXTRA + 1);
   localparam logic [31:0] BUCKET_DIV =
      32'd1 + ({1'b0, LEHMER_MOD} - 32'd1) / 32'(TABLE_WORDS);

   logic [31:0]      gen_ff, gen_in;
   logic [30:0]      last_ff, last_in;
   logic [46:0]      prod_ff;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [30:0]      rd_ff;
   logic [30:0]      out_ff;
   logic [30:0]      shuf_mem [TABLE_WORDS];

   logic [31:0]      fold_sum;
   logic [31:0]      fold_red;
   logic [30:0]      fold_val;
   logic [31:0]      start_val;
   logic             fill_en;

   // fold: 2^31 == 1 mod M, so high part adds to low part, then one subtract
   assign fold_sum = {16'b0, prod_ff[46:31]} + {1'b0, prod_ff[30:0]};
   assign fold_red = (fold_sum >= {1'b0, LEHMER_MOD}) ? fold_sum - {1'b0, LEHMER_MOD}
                                                      : fold_sum;
   assign fold_val = fold_red[30:0];

   // magnitude of a negative seed, else 1
   assign start_val = gen_ff[31] ? (~gen_ff + 32'd1) : 32'd1;
   assign fill_en   = cmd.init_step && (cnt_ff < CNT_W'(TABLE_WORDS));

   assign sts.need_init = gen_ff[31] || (gen_ff == 32'd0) || (last_ff == 31'd0);
   assign sts.cnt_zero  = (cnt_ff == '0);
   assign rsp_uniform_value = out_ff;

   // bucket index of the last output: independent threshold compares
   always_comb begin
      idx_in = '0;
      for (int k = 1; k < TABLE_WORDS; k++) begin
         if ({1'b0, last_ff} >= 32'(k) * BUCKET_DIV) begin
            idx_in = IDX_W'(k);
         end
      end
   end

   always_comb begin
      gen_in  = gen_ff;
      last_in = last_ff;
      cnt_in  = cnt_ff;
      if (cmd.load_seed) begin
         gen_in = req_seed_value;
      end
      if (cmd.start_init) begin
         gen_in = start_val;
         cnt_in = CNT_W'(TABLE_WORDS + WARM_EXTRA);
      end
      if (cmd.init_step) begin
         gen_in = {1'b0, fold_val};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == '0) begin
            last_in = fold_val;
         end
      end
      if (cmd.draw_step) begin
         gen_in = {1'b0, fold_val};
      end
      if (cmd.finish) begin
         last_in = rd_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gen_ff  <= '0;
         last_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         gen_ff  <= gen_in;
         last_ff <= last_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= {15'b0, gen_ff} * {32'b0, LEHMER_MUL};
      idx_ff  <= idx_in;
      if (cmd.finish) begin
         out_ff <= rd_ff;
      end
   end

   // shuffle memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (fill_en) begin
         shuf_mem[cnt_ff[IDX_W-1:0]] <= fold_val;
      end else if (cmd.finish) begin
         shuf_mem[idx_ff] <= gen_ff[30:0];
      end
      if (cmd.draw_step) begin
         rd_ff <= shuf_mem[idx_ff];
      end
   end

endmodule

[hdl/shuffled_lehmer_uniform_generator.sv]
// A load beat is taken only while idle, one load per cycle, and raises no result. A draw
// runs the shared multiply/fold step, then a finish step that waits for a free result
// register; no beat is taken until it is done. Re-seeding adds TABLE_WORDS+8 warm-up steps.
// Reset is synchronous: clears core state, last output and result valid; the shuffle
// memory is not cleared, since the first draw after reset always refills it.
`timescale 1ns / 1ps

// Top level: Lehmer core with a Bays-Durham shuffle table.
// Depends on slug_pkg, slug_ctrl, slug_dp.
module shuffled_lehmer_uniform_generator import slug_pkg::*; #(
   parameter int TABLE_WORDS = DEF_TABLE_WORDS
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_func,
   input  logic signed [31:0] req_seed_value,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic        [30:0] rsp_uniform_value
);

   slug_cmd_type cmd;
   slug_sts_type sts;

   // Controller: accept beats, sequence warm-up and draw steps, hold the
   // result beat until taken.
   slug_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_func  (req_func),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   // Datapath: core register advanced by a registered 32x15 multiply and a
   // mod (2^31-1) fold; the shuffle memory swaps one entry per draw.
   slug_dp #(
      .TABLE_WORDS (TABLE_WORDS)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .req_seed_value    (req_seed_value),
      .rsp_uniform_value (rsp_uniform_value)
   );

endmodule

[hdl/slug_chk.sv]
// Port-level checker for the shuffled Lehmer uniform generator, bound to the top.
// Depends on slug_pkg and the macros header.
`timescale 1ns / 1ps
`include "shuffled_lehmer_uniform_generator_macros.svh"

module slug_chk import slug_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        req_func,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [30:0] rsp_uniform_value
);

   `SLUG_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_uniform_value), "result beat dropped or changed while stalled")
   `SLUG_ASSERT_NEXT(a_draw_busy, req_valid && req_ready && (req_func == FUNC_DRAW), !req_ready, "draw accepted but input still ready")
   `SLUG_ASSERT_NEXT(a_load_silent, req_valid && req_ready && (req_func == FUNC_LOAD) && !rsp_valid, !rsp_valid, "load beat produced a result")
   `SLUG_ASSERT_RESET(a_reset_clear, !rsp_valid, "result valid after reset")

endmodule

bind shuffled_lehmer_uniform_generator slug_chk u_slug_chk (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_ready         (req_ready),
   .req_func          (req_func),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_uniform_value (rsp_uniform_value)
);
